>>> design/cesd_pkg.sv
// ----------------------------------------------------------------------------
// cesd_pkg
// Shared types, constants and decode helpers for the C escape sequence decoder.
// ----------------------------------------------------------------------------
package cesd_pkg;

  localparam int unsigned FifoDepthDefault = 4;

  localparam logic [7:0] ChrNul       = 8'h00;
  localparam logic [7:0] ChrBackslash = 8'h5c;
  localparam logic [7:0] ChrZero      = 8'h30;
  localparam logic [7:0] ChrSeven     = 8'h37;
  localparam logic [7:0] ChrNine      = 8'h39;
  localparam logic [7:0] ChrUpA       = 8'h41;
  localparam logic [7:0] ChrUpF       = 8'h46;
  localparam logic [7:0] ChrUpU       = 8'h55;
  localparam logic [7:0] ChrLoA       = 8'h61;
  localparam logic [7:0] ChrLoB       = 8'h62;
  localparam logic [7:0] ChrLoF       = 8'h66;
  localparam logic [7:0] ChrLoN       = 8'h6e;
  localparam logic [7:0] ChrLoR       = 8'h72;
  localparam logic [7:0] ChrLoT       = 8'h74;
  localparam logic [7:0] ChrLoU       = 8'h75;
  localparam logic [7:0] ChrLoV       = 8'h76;
  localparam logic [7:0] ChrLoX       = 8'h78;
  localparam logic [7:0] ChrQuote     = 8'h27;
  localparam logic [7:0] ChrDquote    = 8'h22;
  localparam logic [7:0] ChrQmark     = 8'h3f;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESC    = 3'd1,
    MODE_OCT1   = 3'd2,
    MODE_OCT2   = 3'd3,
    MODE_HEX    = 3'd4
  } mode_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       warn;
    logic       last;
  } res_t;

  // One queue entry: one or two results of a single input item.
  typedef struct packed {
    logic two;
    res_t res0;
    res_t res1;
  } entry_t;

  function automatic logic is_oct(input logic [7:0] c);
    return (c >= ChrZero) && (c <= ChrSeven);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= ChrZero) && (c <= ChrNine)) || ((c >= ChrUpA) && (c <= ChrUpF)) ||
           ((c >= ChrLoA) && (c <= ChrLoF));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    v = c[3:0];
    if (c >= ChrUpA) begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

  function automatic logic is_hex_intro(input logic [7:0] c);
    return (c == ChrLoX) || (c == ChrLoU) || (c == ChrUpU);
  endfunction

  // Map a simple escape character; unknown characters come back with warn set.
  function automatic res_t simple_esc(input logic [7:0] c);
    res_t r;
    r.out_byte = c;
    r.warn     = 1'b0;
    r.last     = 1'b0;
    case (c)
      ChrLoA:    r.out_byte = 8'd7;
      ChrLoB:    r.out_byte = 8'd8;
      ChrLoF:    r.out_byte = 8'd12;
      ChrLoN:    r.out_byte = 8'd10;
      ChrLoR:    r.out_byte = 8'd13;
      ChrLoT:    r.out_byte = 8'd9;
      ChrLoV:    r.out_byte = 8'd11;
      ChrQuote, ChrDquote, ChrBackslash, ChrQmark: r.out_byte = c;
      default:   r.warn = 1'b1;
    endcase
    return r;
  endfunction

endpackage

>>> design/cesd_in_if.sv
// ----------------------------------------------------------------------------
// cesd_in_if
// Input channel: literal body bytes with an end-of-string marker.
// ----------------------------------------------------------------------------
interface cesd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

>>> design/cesd_out_if.sv
// ----------------------------------------------------------------------------
// cesd_out_if
// Output channel: decoded bytes with warning and last flags.
// ----------------------------------------------------------------------------
interface cesd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       warn;
  logic       last;

  modport source (output valid, output out_byte, output warn, output last, input ready);
  modport sink   (input valid, input out_byte, input warn, input last, output ready);
endinterface

>>> design/c_escape_sequence_decoder_unit.sv
// ----------------------------------------------------------------------------
// c_escape_sequence_decoder_unit
// Streaming decoder for the body of a C string literal.
//
// The in_i channel takes one byte of the literal body per transaction; an
// end_of_string transaction or a zero byte closes the literal. The out_o
// channel gives decoded bytes; the terminating zero carries last, and warn
// marks bytes from unknown escapes or a terminator after a lone backslash.
// An input byte yields zero, one or two output transactions.
// Throughput: one input transaction per cycle while the queue has room and
// one output transaction per cycle while the receiver is ready; an item with
// two results gives two output transactions. An input item is written into
// the queue, then loaded into the output register once that register is free.
// The front decoder feeds a FifoDepth-entry queue; in_i.ready drops only
// while that queue is full, so a stalled receiver backs up into the queue
// first. Reset clears the decoder to normal text and empties the queue and
// the output register.
// ----------------------------------------------------------------------------
module c_escape_sequence_decoder_unit
  import cesd_pkg::*;
#(
  parameter int unsigned FifoDepth = FifoDepthDefault
) (
  input logic  clk_i,
  input logic  rst_ni,
  cesd_in_if.sink    in_i,
  cesd_out_if.source out_o
);

  logic   q_push, q_full, q_pop, q_empty;
  entry_t q_wr_entry, q_rd_entry;

  cesd_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i      (in_i.valid),
    .in_ready_o      (in_i.ready),
    .in_byte_i       (in_i.in_byte),
    .end_of_string_i (in_i.end_of_string),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_entry_o       (q_wr_entry)
  );

  cesd_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (q_push),
    .entry_i (q_wr_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .entry_o (q_rd_entry)
  );

  cesd_back u_back (
    .clk_i,
    .rst_ni,
    .q_empty_i   (q_empty),
    .q_entry_i   (q_rd_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_byte_o  (out_o.out_byte),
    .warn_o      (out_o.warn),
    .last_o      (out_o.last)
  );

endmodule

>>> design/cesd_front.sv
// ----------------------------------------------------------------------------
// cesd_front
// Accepts input bytes, runs the escape state machine and builds queue entries.
// ----------------------------------------------------------------------------
module cesd_front
  import cesd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_string_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output entry_t     q_entry_o
);

  mode_e      mode_q, mode_d;
  logic [7:0] val_q, val_d;
  logic       accept;
  logic       is_end;
  logic       pending;
  logic       emit;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign is_end     = end_of_string_i || (in_byte_i == ChrNul);
  assign pending    = (mode_q == MODE_OCT1) || (mode_q == MODE_OCT2) || (mode_q == MODE_HEX);
  assign q_push_o   = accept && emit;

  always_comb begin
    mode_d = mode_q;
    val_d  = val_q;
    if (is_end) begin
      mode_d = MODE_NORMAL;
      val_d  = '0;
    end else begin
      case (mode_q)
        MODE_ESC: begin
          if (is_oct(in_byte_i)) begin
            val_d  = {5'd0, in_byte_i[2:0]};
            mode_d = MODE_OCT1;
          end else if (is_hex_intro(in_byte_i)) begin
            val_d  = '0;
            mode_d = MODE_HEX;
          end else begin
            mode_d = MODE_NORMAL;
          end
        end
        MODE_OCT1: begin
          if (is_oct(in_byte_i)) begin
            val_d  = {val_q[4:0], in_byte_i[2:0]};
            mode_d = MODE_OCT2;
          end else begin
            val_d  = '0;
            mode_d = (in_byte_i == ChrBackslash) ? MODE_ESC : MODE_NORMAL;
          end
        end
        MODE_OCT2: begin
          val_d = '0;
          if (is_oct(in_byte_i)) begin
            mode_d = MODE_NORMAL;
          end else begin
            mode_d = (in_byte_i == ChrBackslash) ? MODE_ESC : MODE_NORMAL;
          end
        end
        MODE_HEX: begin
          if (is_hex(in_byte_i)) begin
            val_d = {val_q[3:0], hex_val(in_byte_i)};
          end else begin
            val_d  = '0;
            mode_d = (in_byte_i == ChrBackslash) ? MODE_ESC : MODE_NORMAL;
          end
        end
        default: begin
          mode_d = (in_byte_i == ChrBackslash) ? MODE_ESC : MODE_NORMAL;
        end
      endcase
    end
  end

  always_comb begin
    emit      = 1'b0;
    q_entry_o = '0;
    if (is_end) begin
      emit = 1'b1;
      if (pending) begin
        q_entry_o.two  = 1'b1;
        q_entry_o.res0 = '{out_byte: val_q, warn: 1'b0, last: 1'b0};
        q_entry_o.res1 = '{out_byte: 8'd0, warn: 1'b0, last: 1'b1};
      end else begin
        q_entry_o.res0 = '{out_byte: 8'd0, warn: (mode_q == MODE_ESC), last: 1'b1};
      end
    end else begin
      case (mode_q)
        MODE_ESC: begin
          if (!is_oct(in_byte_i) && !is_hex_intro(in_byte_i)) begin
            emit           = 1'b1;
            q_entry_o.res0 = simple_esc(in_byte_i);
          end
        end
        MODE_OCT1, MODE_HEX: begin
          if ((mode_q == MODE_OCT1) ? !is_oct(in_byte_i) : !is_hex(in_byte_i)) begin
            emit           = 1'b1;
            q_entry_o.res0 = '{out_byte: val_q, warn: 1'b0, last: 1'b0};
            q_entry_o.res1 = '{out_byte: in_byte_i, warn: 1'b0, last: 1'b0};
            q_entry_o.two  = (in_byte_i != ChrBackslash);
          end
        end
        MODE_OCT2: begin
          emit = 1'b1;
          if (is_oct(in_byte_i)) begin
            q_entry_o.res0 = '{out_byte: {val_q[4:0], in_byte_i[2:0]}, warn: 1'b0, last: 1'b0};
          end else begin
            q_entry_o.res0 = '{out_byte: val_q, warn: 1'b0, last: 1'b0};
            q_entry_o.res1 = '{out_byte: in_byte_i, warn: 1'b0, last: 1'b0};
            q_entry_o.two  = (in_byte_i != ChrBackslash);
          end
        end
        default: begin
          if (in_byte_i != ChrBackslash) begin
            emit           = 1'b1;
            q_entry_o.res0 = '{out_byte: in_byte_i, warn: 1'b0, last: 1'b0};
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
      val_q  <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      val_q  <= val_d;
    end
  end

endmodule

>>> design/cesd_fifo.sv
// ----------------------------------------------------------------------------
// cesd_fifo
// Small queue of decoded entries between the front and the back.
// ----------------------------------------------------------------------------
module cesd_fifo
  import cesd_pkg::*;
#(
  parameter int unsigned Depth = FifoDepthDefault
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   empty_o,
  output entry_t entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> design/cesd_back.sv
// ----------------------------------------------------------------------------
// cesd_back
// Unpacks queue entries into one registered output transaction per result.
// ----------------------------------------------------------------------------
module cesd_back
  import cesd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  entry_t     q_entry_i,
  output logic       q_pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       warn_o,
  output logic       last_o
);

  logic sel_q;
  logic valid_q;
  res_t res_q;
  logic load;
  logic entry_done;

  assign load       = (!valid_q || out_ready_i) && !q_empty_i;
  assign entry_done = sel_q || !q_entry_i.two;
  assign q_pop_o    = load && entry_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        sel_q   <= !entry_done;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= sel_q ? q_entry_i.res1 : q_entry_i.res0;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = res_q.out_byte;
  assign warn_o      = res_q.warn;
  assign last_o      = res_q.last;

endmodule

>>> dv/cesd_checker.sv
// ----------------------------------------------------------------------------
// cesd_checker
// Watches both channels of the escape decoder. Every accepted input byte is
// decoded by a local model of the literal decoder, and the decoded bytes are
// queued. Each output transaction is compared field by field against the
// oldest queued byte. The failure count and the number of bytes still owed
// go back to the testbench top.
// ----------------------------------------------------------------------------
module cesd_checker
  import cesd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  cesd_in_if   in_mon,
  cesd_out_if  out_mon,
  output int   fail_count_o,
  output int   pending_o
);

  res_t       decoded_q[$];
  mode_e      dec_mode;
  logic [7:0] esc_val;
  int         fail_cnt;
  int         mismatch_cnt;

  function automatic void owe_byte(input logic [7:0] b, input logic w, input logic l);
    res_t r;
    r.out_byte = b;
    r.warn     = w;
    r.last     = l;
    decoded_q.push_back(r);
  endfunction

  function automatic void text_byte(input logic [7:0] c);
    if (c == ChrBackslash) begin
      dec_mode = MODE_ESC;
    end else begin
      dec_mode = MODE_NORMAL;
      owe_byte(c, 1'b0, 1'b0);
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] c, input logic eos);
    logic       is_oct_dig;
    logic       is_hex_dig;
    logic [3:0] dig;
    logic [7:0] val;
    logic       wrn;
    logic       flush;
    is_oct_dig = (c >= ChrZero) && (c <= ChrSeven);
    is_hex_dig = 1'b1;
    dig        = '0;
    flush      = 1'b0;
    if ((c >= ChrZero) && (c <= ChrNine)) begin
      dig = 4'(c - ChrZero);
    end else if ((c >= ChrLoA) && (c <= ChrLoF)) begin
      dig = 4'(c - ChrLoA + 8'd10);
    end else if ((c >= ChrUpA) && (c <= ChrUpF)) begin
      dig = 4'(c - ChrUpA + 8'd10);
    end else begin
      is_hex_dig = 1'b0;
    end

    if (eos || (c == ChrNul)) begin
      if ((dec_mode == MODE_OCT1) || (dec_mode == MODE_OCT2) || (dec_mode == MODE_HEX)) begin
        owe_byte(esc_val, 1'b0, 1'b0);
      end
      owe_byte(ChrNul, dec_mode == MODE_ESC, 1'b1);
      dec_mode = MODE_NORMAL;
      esc_val  = '0;
      return;
    end

    case (dec_mode)
      MODE_ESC: begin
        if (is_oct_dig) begin
          esc_val  = c - ChrZero;
          dec_mode = MODE_OCT1;
        end else if ((c == ChrLoX) || (c == ChrLoU) || (c == ChrUpU)) begin
          esc_val  = '0;
          dec_mode = MODE_HEX;
        end else begin
          val = c;
          wrn = 1'b0;
          case (c)
            ChrLoA: val = 8'd7;
            ChrLoB: val = 8'd8;
            ChrLoF: val = 8'd12;
            ChrLoN: val = 8'd10;
            ChrLoR: val = 8'd13;
            ChrLoT: val = 8'd9;
            ChrLoV: val = 8'd11;
            ChrQuote, ChrDquote, ChrBackslash, ChrQmark: ;
            default: wrn = 1'b1;
          endcase
          dec_mode = MODE_NORMAL;
          owe_byte(val, wrn, 1'b0);
        end
      end
      MODE_OCT1: begin
        if (is_oct_dig) begin
          esc_val  = {esc_val[4:0], 3'b000} + (c - ChrZero);
          dec_mode = MODE_OCT2;
        end else begin
          flush = 1'b1;
        end
      end
      MODE_OCT2: begin
        if (is_oct_dig) begin
          owe_byte({esc_val[4:0], 3'b000} + (c - ChrZero), 1'b0, 1'b0);
          esc_val  = '0;
          dec_mode = MODE_NORMAL;
        end else begin
          flush = 1'b1;
        end
      end
      MODE_HEX: begin
        if (is_hex_dig) begin
          esc_val = {esc_val[3:0], dig};
        end else begin
          flush = 1'b1;
        end
      end
      default: text_byte(c);
    endcase

    if (flush) begin
      owe_byte(esc_val, 1'b0, 1'b0);
      esc_val = '0;
      text_byte(c);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    res_t got;
    if (!rst_ni) begin
      decoded_q.delete();
      dec_mode     = MODE_NORMAL;
      esc_val      = '0;
      fail_cnt     = 0;
      mismatch_cnt = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.out_byte = out_mon.out_byte;
        got.warn     = out_mon.warn;
        got.last     = out_mon.last;
        if (decoded_q.size() == 0) begin
          fail_cnt++;
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("[%0t] unexpected transaction: byte %02h warn %0b last %0b",
                     $realtime, got.out_byte, got.warn, got.last);
          end
        end else begin
          want = decoded_q.pop_front();
          if ((got.out_byte !== want.out_byte) || (got.warn !== want.warn) ||
              (got.last !== want.last)) begin
            fail_cnt++;
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("[%0t] mismatch: expected byte %02h warn %0b last %0b, got byte %02h warn %0b last %0b",
                       $realtime, want.out_byte, want.warn, want.last,
                       got.out_byte, got.warn, got.last);
            end
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        decode_byte(in_mon.in_byte, in_mon.end_of_string);
      end
      fail_count_o <= fail_cnt;
      pending_o    <= decoded_q.size();
    end
  end

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the C escape sequence decoder. A short directed
// run hits plain bytes, simple, unknown, octal and hex escapes, overflow,
// pending values flushed by text or by the end, and a trailing backslash.
// Random literals follow, mixing plain text, well-formed escapes and raw noise,
// under three sender/receiver stall profiles. Checking is done by
// cesd_checker.
// ----------------------------------------------------------------------------
module tb_top
  import cesd_pkg::*;
();

  localparam int RandomItems  = 500;
  localparam int IdleLimit    = 2000;
  localparam int DrainCycles  = 10;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   items_sent;
  int   idle_cycles;
  int   fail_count;
  int   pending;

  logic [7:0] simple_chars [11] = '{ChrLoA, ChrLoB, ChrLoF, ChrLoN, ChrLoR, ChrLoT, ChrLoV,
                                    ChrQuote, ChrDquote, ChrQmark, ChrBackslash};

  cesd_in_if  in_if ();
  cesd_out_if out_if ();

  c_escape_sequence_decoder_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  cesd_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [7:0] c, input logic eos);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.in_byte       <= c;
    in_if.end_of_string <= eos;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
  endtask

  task automatic send_hex_digit();
    int d;
    d = $urandom_range(0, 15);
    if (d < 10) begin
      send_item(ChrZero + 8'(d), 1'b0);
    end else begin
      send_item(($urandom_range(0, 1) ? ChrUpA : ChrLoA) + 8'(d - 10), 1'b0);
    end
  endtask

  task automatic send_literal();
    int         n_elems;
    int         kind;
    logic [7:0] ch;
    n_elems = $urandom_range(0, 12);
    repeat (n_elems) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        ch = 8'($urandom_range(1, 255));
        send_item((ch == ChrBackslash) ? ChrUpA : ch, 1'b0);
      end else if (kind < 50) begin
        send_item(ChrBackslash, 1'b0);
        send_item(simple_chars[$urandom_range(0, 10)], 1'b0);
      end else if (kind < 65) begin
        send_item(ChrBackslash, 1'b0);
        repeat ($urandom_range(1, 3)) send_item(ChrZero + 8'($urandom_range(0, 7)), 1'b0);
      end else if (kind < 80) begin
        send_item(ChrBackslash, 1'b0);
        case ($urandom_range(0, 2))
          0:       send_item(ChrLoX, 1'b0);
          1:       send_item(ChrLoU, 1'b0);
          default: send_item(ChrUpU, 1'b0);
        endcase
        repeat ($urandom_range(0, 4)) send_hex_digit();
      end else if (kind < 90) begin
        send_item(ChrBackslash, 1'b0);
        send_item(8'($urandom_range(1, 255)), 1'b0);
      end else begin
        send_item(8'($urandom_range(0, 255)), 1'b0);
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      send_item(ChrBackslash, 1'b0);
    end
    if ($urandom_range(0, 1)) begin
      send_item(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      send_item(ChrNul, 1'b0);
    end
  endtask

  initial begin
    rst_ni              = 1'b0;
    in_if.valid         = 1'b0;
    in_if.in_byte       = '0;
    in_if.end_of_string = 1'b0;
    send_idle_pct       = 17;
    recv_idle_pct       = 77;
    items_sent          = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(ChrUpA, 1'b0);
    send_item(8'hff, 1'b0);
    send_item(ChrBackslash, 1'b0);
    send_item(ChrLoN, 1'b0);
    send_item(ChrBackslash, 1'b0);
    send_item(8'h71, 1'b0);
    send_item(ChrBackslash, 1'b0);
    send_item(ChrSeven, 1'b0);
    send_item(ChrSeven, 1'b0);
    send_item(ChrSeven, 1'b0);
    send_item(ChrBackslash, 1'b0);
    send_item(ChrZero + 8'd1, 1'b0);
    send_item(ChrUpA + 8'd6, 1'b0);
    send_item(ChrBackslash, 1'b0);
    send_item(ChrLoX, 1'b0);
    send_item(ChrUpF, 1'b0);
    send_item(ChrLoF, 1'b0);
    send_item(ChrZero + 8'd1, 1'b0);
    send_item(ChrBackslash, 1'b0);
    send_item(ChrUpU, 1'b0);
    send_item(ChrBackslash, 1'b1);
    send_item(ChrBackslash, 1'b0);
    send_item(ChrNul, 1'b0);

    while (items_sent < RandomItems) begin
      if (items_sent > (2 * RandomItems) / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (items_sent > RandomItems / 3) begin
        send_idle_pct = 77;
        recv_idle_pct = 17;
      end
      send_literal();
    end
    in_if.valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if ((fail_count == 0) && (pending == 0)) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
